// ===== rtl/fltw_pkg.sv =====
// Package for the four-level page table walk block.
// Holds the operation and status codes, entry bit positions and the sequencer state type.
// No dependencies.
package fltw_pkg;

   typedef enum logic [1:0] {
      OP_TRANSLATE = 2'd0,
      OP_MAP_PAGE  = 2'd1,
      OP_MAP_HUGE  = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_MISALIGNED = 2'd1,
      ST_CONFLICT   = 2'd2,
      ST_EXHAUSTED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_DONE
   } state_type;

   localparam int unsigned ENTRY_BITS  = 9;
   localparam int unsigned BIT_PRESENT = 0;
   localparam int unsigned BIT_HUGE    = 7;
   localparam logic [11:0] DIR_FLAGS   = 12'h007;

endpackage

// ===== rtl/four_level_page_table_map_walk.sv =====
// Four-level page table store with translate, map-4KB and map-identity-2MB operations.
// Uses fltw_pkg for codes and types.
//
// Usage: one request beat on req_* carries operation, virtual and physical address and leaf
// flags; exactly one response beat on rsp_* returns status, translated address and a mapped
// flag. Table pages live in one synchronous memory of TABLE_PAGES*512 64-bit entries, read
// through a single port whose read data is registered.
// Each walk level issues the read, then evaluates the data and maybe writes a new directory
// entry. The response beat follows the last level visited; a misaligned or unused operation
// visits no level and goes straight to the response. The chain of dependent table reads
// through the single memory port sets how long an item takes.
// The block works on one item at a time; req_tready is high only when idle with no response
// beat waiting.
// After reset a clearing pass writes zero to every entry, one a cycle; no request is taken
// during the pass. The table page counter restarts at one.
// When the receiver stalls, the response is held in its register until taken.
module four_level_page_table_map_walk #(
   parameter int unsigned TABLE_PAGES = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // operation[1:0], virt_addr[49:2], phys_addr[101:50], entry_flags[113:102], zero fill
   input  logic [119:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[1:0], translated_addr[53:2], is_mapped[54], zero fill
   output logic [55:0]   rsp_tdata
);
   import fltw_pkg::*;

   localparam int unsigned PAGE_BITS = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int unsigned CNT_BITS  = $clog2(TABLE_PAGES + 1);
   localparam int unsigned ADDR_BITS = PAGE_BITS + ENTRY_BITS;
   localparam int unsigned DEPTH     = TABLE_PAGES * 512;

   // Table store.
   logic [63:0] mem [DEPTH];
   logic [63:0] rdata_ff;
   logic        we;
   logic [ADDR_BITS-1:0] waddr, raddr;
   logic [63:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // Control and payload registers.
   state_type state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [CNT_BITS-1:0]  free_ff, free_in;
   logic [1:0]   op_ff, op_in;
   logic [47:0]  va_ff, va_in;
   logic [51:0]  pa_ff, pa_in;
   logic [11:0]  fl_ff, fl_in;
   logic [1:0]   lvl_ff, lvl_in;     // 0: level 4 ... 3: level 1
   logic [39:0]  page_ff, page_in;   // current table page number
   logic         rv_ff, rv_in;
   logic [1:0]   st_ff, st_in;
   logic [51:0]  ta_ff, ta_in;
   logic         mp_ff, mp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         free_ff  <= CNT_BITS'(1);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         free_ff  <= free_in;
         rv_ff    <= rv_in;
      end
      op_ff <= op_in; va_ff <= va_in; pa_ff <= pa_in; fl_ff <= fl_in;
      lvl_ff <= lvl_in; page_ff <= page_in; st_ff <= st_in; ta_ff <= ta_in; mp_ff <= mp_in;
   end

   // Index of the current level from the virtual address.
   logic [ENTRY_BITS-1:0] idx;
   logic                  page_ok;
   always_comb begin
      unique case (lvl_ff)
         2'd0: idx = va_ff[47:39];
         2'd1: idx = va_ff[38:30];
         2'd2: idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
      page_ok = (page_ff < 40'(TABLE_PAGES));
   end

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {1'b0, mp_ff, ta_ff, st_ff};

   // Next state.
   logic rd_present, rd_huge, at_leaf, need_dir;
   always_comb begin
      rd_present = rdata_ff[BIT_PRESENT];
      rd_huge    = rdata_ff[BIT_HUGE];
      // Leaf write level: level 1 for map-page, level 2 for map-huge.
      at_leaf  = (op_ff == OP_MAP_PAGE) ? (lvl_ff == 2'd3) : (lvl_ff == 2'd2);
      need_dir = !rd_present && !at_leaf;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == ADDR_BITS'(DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: if (req_tvalid && req_tready) begin
            if (req_tdata[1:0] == OP_NONE) state_in = S_DONE;
            else if (req_tdata[1:0] == OP_TRANSLATE) state_in = S_READ;
            else if (req_tdata[1:0] == OP_MAP_PAGE &&
                     (req_tdata[13:2] != 12'd0 || req_tdata[61:50] != 12'd0))
               state_in = S_DONE;
            else if (req_tdata[1:0] == OP_MAP_HUGE && req_tdata[22:2] != 21'd0)
               state_in = S_DONE;
            else state_in = S_READ;
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            state_in = S_DONE;
            if (op_ff == OP_TRANSLATE) begin
               if (rd_present && page_ok && !(lvl_ff == 2'd2 && rd_huge) && lvl_ff != 2'd3)
                  state_in = S_READ;
            end else if (op_ff == OP_MAP_HUGE && lvl_ff == 2'd2) begin
               state_in = S_DONE;
            end else if (op_ff == OP_MAP_PAGE && lvl_ff == 2'd3) begin
               state_in = S_DONE;
            end else if (op_ff == OP_MAP_PAGE && lvl_ff == 2'd2 && page_ok && rd_huge) begin
               state_in = S_DONE;
            end else if (!(need_dir && free_ff >= CNT_BITS'(TABLE_PAGES))) begin
               state_in = S_READ;
            end
         end
         S_DONE: if (!rv_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   logic [63:0] rd_eff;
   always_comb begin
      rd_eff  = page_ok ? rdata_ff : 64'd0;
      clr_in  = clr_ff;
      free_in = free_ff;
      op_in = op_ff; va_in = va_ff; pa_in = pa_ff; fl_in = fl_ff;
      lvl_in = lvl_ff; page_in = page_ff;
      st_in = st_ff; ta_in = ta_ff; mp_in = mp_ff;
      rv_in = rv_ff;
      we    = 1'b0;
      waddr = {page_ff[PAGE_BITS-1:0], idx};
      wdata = 64'd0;
      raddr = {page_ff[PAGE_BITS-1:0], idx};
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            we = 1'b1; waddr = clr_ff; clr_in = clr_ff + 1'b1;
         end
         S_IDLE: if (req_tvalid && req_tready) begin
            op_in = req_tdata[1:0]; va_in = req_tdata[49:2];
            pa_in = req_tdata[101:50]; fl_in = req_tdata[113:102];
            lvl_in = 2'd0; page_in = 40'd0;
            ta_in = 52'd0; mp_in = 1'b0;
            st_in = ST_OK;
            if ((req_tdata[1:0] == OP_MAP_PAGE &&
                 (req_tdata[13:2] != 12'd0 || req_tdata[61:50] != 12'd0)) ||
                (req_tdata[1:0] == OP_MAP_HUGE && req_tdata[22:2] != 21'd0))
               st_in = ST_MISALIGNED;
         end
         S_READ: ;
         S_EVAL: begin
            if (op_ff == OP_TRANSLATE) begin
               if (rd_eff[BIT_PRESENT]) begin
                  if (lvl_ff == 2'd2 && rd_eff[BIT_HUGE]) begin
                     mp_in = 1'b1; ta_in = {rd_eff[51:21], va_ff[20:0]};
                  end else if (lvl_ff == 2'd3) begin
                     mp_in = 1'b1; ta_in = {rd_eff[51:12], va_ff[11:0]};
                  end
               end
               page_in = rd_eff[51:12]; lvl_in = lvl_ff + 2'd1;
            end else if (at_leaf) begin
               we = page_ok;
               wdata = (op_ff == OP_MAP_PAGE) ?
                       {12'd0, pa_ff[51:12], fl_ff | 12'h001} :
                       {16'd0, va_ff[47:12], fl_ff | 12'h080};
            end else if (op_ff == OP_MAP_PAGE && lvl_ff == 2'd2 && rd_eff[BIT_HUGE]) begin
               st_in = ST_CONFLICT;
            end else if (rd_eff[BIT_PRESENT]) begin
               page_in = rd_eff[51:12]; lvl_in = lvl_ff + 2'd1;
            end else if (free_ff >= CNT_BITS'(TABLE_PAGES)) begin
               st_in = ST_EXHAUSTED;
            end else begin
               we = page_ok;
               wdata = {12'd0, 40'(free_ff), DIR_FLAGS};
               page_in = 40'(free_ff); lvl_in = lvl_ff + 2'd1;
               free_in = free_ff + 1'b1;
            end
         end
         S_DONE: if (!rv_ff || rsp_tready) rv_in = 1'b1;
         default: ;
      endcase
   end

   // The page counter never passes the pool size.
   assert property (@(posedge clock) disable iff (reset) free_ff <= CNT_BITS'(TABLE_PAGES))
      else $error("table page counter beyond pool");
   // A request is only taken outside the clearing pass and with no response pending.
   assert property (@(posedge clock) disable iff (reset)
                    (req_tvalid && req_tready) |-> !rv_ff)
      else $error("request taken while response pending");
   // Only map operations allocate directory pages.
   assert property (@(posedge clock) disable iff (reset)
                    (free_in != free_ff) |-> (op_ff == OP_MAP_PAGE || op_ff == OP_MAP_HUGE))
      else $error("allocation outside a map operation");
   // Memory writes happen only while clearing or evaluating a map step.
   assert property (@(posedge clock) disable iff (reset)
                    we |-> (state_ff == S_CLEAR || state_ff == S_EVAL))
      else $error("unexpected table write");

endmodule
